FILE: design/white_blob_steering_top_assert.svh
// Assertion macros of the white blob steering design.
`ifndef WHITE_BLOB_STEERING_TOP_ASSERT_SVH
`define WHITE_BLOB_STEERING_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("white blob steering: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("white blob steering: next-cycle check failed");

`endif

FILE: design/wbs_pkg.sv
// Shared constants, codes and types of the white blob steering block.
`default_nettype none
package wbs_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_BITS       = 12;
  localparam int CFG_INDEX_BITS = 1;
  localparam int IDX_BITS       = 24;
  localparam int CNT_BITS       = 24;
  localparam int SUM_BITS       = 36;
  localparam int MEAN_BITS      = 12;
  localparam int DIV_STEPS      = SUM_BITS;
  localparam int STEP_BITS      = $clog2(DIV_STEPS);

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

  // floor(x/3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2^15.
  localparam logic [16:0] RECIP3       = 17'd43691;
  localparam int          RECIP3_SHIFT = 17;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    STEER_SEARCH   = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_STRAIGHT = 2'd2,
    STEER_RIGHT    = 2'd3
  } steer_t;

  typedef struct packed {
    logic pixel_take;
    logic frame_close;
    logic div_step;
    logic result_load;
  } cmd_t;
endpackage
`default_nettype wire

FILE: design/wbs_pixel_if.sv
// Pixel input channel.
`default_nettype none
interface wbs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, red, green, blue, frame_end, input ready);
  modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface
`default_nettype wire

FILE: design/wbs_result_if.sv
// Steering result channel.
`default_nettype none
interface wbs_result_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        steer;
  logic [wbs_pkg::MEAN_BITS-1:0]     mean_column;
  logic [wbs_pkg::CNT_BITS-1:0]      white_count;

  modport source (output valid, steer, mean_column, white_count, input ready);
  modport sink   (input valid, steer, mean_column, white_count, output ready);
endinterface
`default_nettype wire

FILE: design/wbs_ctrl.sv
// Controller: accepts pixels, sequences the per-frame division and the result word.
`default_nettype none
`include "white_blob_steering_top_assert.svh"
module wbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_frame_end,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output wbs_pkg::cmd_t cmd
);
  typedef enum logic [1:0] {S_ACC, S_DIV, S_LOAD} state_t;

  state_t                          state;
  logic [wbs_pkg::STEP_BITS-1:0]   step_count;
  logic                            take;
  logic                            load;

  assign in_ready = (state == S_ACC);
  assign take     = in_valid && in_ready;
  assign load     = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    cmd.pixel_take  = take;
    cmd.frame_close = take && in_frame_end;
    cmd.div_step    = (state == S_DIV);
    cmd.result_load = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_ACC;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (take && in_frame_end) begin
            state      <= S_DIV;
            step_count <= '0;
          end
        end
        S_DIV: begin
          if (step_count == wbs_pkg::STEP_BITS'(wbs_pkg::DIV_STEPS - 1)) begin
            state      <= S_LOAD;
            step_count <= '0;
          end else begin
            step_count <= step_count + 1'b1;
          end
        end
        S_LOAD: begin
          if (load) begin
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
      // A loaded word replaces one that is being taken in the same cycle.
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `WBS_ASSERT_NEXT(a_close_starts_div, take && in_frame_end, state == S_DIV && step_count == '0)
  `WBS_ASSERT_NOW(a_count_only_in_div, step_count != '0, state == S_DIV)
  `WBS_ASSERT_NEXT(a_load_gives_word, load, out_valid && in_ready)
endmodule
`default_nettype wire

FILE: design/wbs_datapath.sv
// Datapath: registers, pixel accumulators, serial divider and result register.
`default_nettype none
module wbs_datapath #(
  parameter int COORD_BITS = wbs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wbs_pkg::cmd_t                       cmd,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  input  logic                                cfg_we,
  input  logic [wbs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wbs_pkg::CFG_BITS-1:0]        cfg_data,
  output logic [1:0]                          steer,
  output logic [wbs_pkg::MEAN_BITS-1:0]       mean_column,
  output logic [wbs_pkg::CNT_BITS-1:0]        white_count
);
  localparam int CB     = wbs_pkg::CFG_BITS;
  localparam int IB     = wbs_pkg::IDX_BITS;
  localparam int NB     = wbs_pkg::CNT_BITS;
  localparam int SB     = wbs_pkg::SUM_BITS;
  localparam int WCMP   = (COORD_BITS > CB ? COORD_BITS : CB) + 1;
  localparam int CMPB   = (COORD_BITS > CB + 1) ? COORD_BITS : CB + 1;
  localparam int SH     = wbs_pkg::RECIP3_SHIFT;

  logic [CB-1:0]         frame_width;
  logic [CB-1:0]         frame_height;
  logic [COORD_BITS-1:0] column;
  logic [IB-1:0]         pixel_index;
  logic [NB-1:0]         white_total;
  logic [SB-1:0]         column_sum;

  logic [NB-1:0]         div_den;
  logic [NB-1:0]         div_rem;
  logic [SB-1:0]         div_quo;
  logic [CB-1:0]         third;
  logic [CB:0]           two_thirds;

  logic [2*CB-1:0]       n_pixels;
  logic [IB+1:0]         p3;
  logic                  in_window;
  logic                  hit;
  logic [NB-1:0]         white_upd;
  logic [SB:0]           sum_add;
  logic [SB-1:0]         sum_upd;
  logic [WCMP-1:0]       col_inc;
  logic [COORD_BITS-1:0] column_next;
  logic [IB-1:0]         index_next;
  logic [NB:0]           rem_sh;
  logic [NB:0]           rem_diff;
  logic                  rem_ge;
  logic [29:0]           prod1;
  logic [29:0]           prod2;
  logic [COORD_BITS-1:0] mean;
  logic [1:0]            steer_next;

  // Window test on pixel boundaries: 3p >= N and 3p + 2 < 2N.
  assign n_pixels  = frame_width * frame_height;
  assign p3        = {2'b00, pixel_index} + {1'b0, pixel_index, 1'b0};
  assign in_window = (p3 >= {2'b00, n_pixels}) && ((p3 + 2'd2) < {1'b0, n_pixels, 1'b0});
  assign hit       = in_window && (&red) && (&green) && (&blue);

  assign white_upd = (hit && !(&white_total)) ? white_total + 1'b1 : white_total;
  assign sum_add   = {1'b0, column_sum} + (SB + 1)'(column);
  assign sum_upd   = !hit ? column_sum : (sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0]);

  assign col_inc     = WCMP'(column) + 1'b1;
  assign column_next = (col_inc >= WCMP'(frame_width)) ? '0 : col_inc[COORD_BITS-1:0];
  assign index_next  = (&pixel_index) ? pixel_index : pixel_index + 1'b1;

  // One restoring division step per cycle.
  assign rem_sh   = {div_rem, div_quo[SB-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_den};
  assign rem_diff = rem_sh - {1'b0, div_den};

  assign prod1 = 30'(frame_width) * 30'(wbs_pkg::RECIP3);
  assign prod2 = 30'({frame_width, 1'b0}) * 30'(wbs_pkg::RECIP3);

  // With a nonzero count the quotient never exceeds the largest column, so its low bits hold it.
  assign mean = div_quo[COORD_BITS-1:0];

  always_comb begin
    if (div_den == '0) begin
      steer_next = wbs_pkg::STEER_SEARCH;
    end else if (CMPB'(mean) < CMPB'(third)) begin
      steer_next = wbs_pkg::STEER_LEFT;
    end else if (CMPB'(mean) > CMPB'(two_thirds)) begin
      steer_next = wbs_pkg::STEER_RIGHT;
    end else begin
      steer_next = wbs_pkg::STEER_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= wbs_pkg::WIDTH_RESET;
      frame_height <= wbs_pkg::HEIGHT_RESET;
      column       <= '0;
      pixel_index  <= '0;
      white_total  <= '0;
      column_sum   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wbs_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          wbs_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.frame_close) begin
        column      <= '0;
        pixel_index <= '0;
        white_total <= '0;
        column_sum  <= '0;
      end else if (cmd.pixel_take) begin
        column      <= column_next;
        pixel_index <= index_next;
        white_total <= white_upd;
        column_sum  <= sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_close) begin
      div_den    <= white_upd;
      div_rem    <= '0;
      div_quo    <= sum_upd;
      third      <= prod1[SH+CB-1:SH];
      two_thirds <= prod2[SH+CB:SH];
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? rem_diff[NB-1:0] : rem_sh[NB-1:0];
      div_quo <= {div_quo[SB-2:0], rem_ge};
    end
    if (cmd.result_load) begin
      steer       <= steer_next;
      mean_column <= (div_den == '0) ? '0 : wbs_pkg::MEAN_BITS'(mean);
      white_count <= div_den;
    end
  end
endmodule
`default_nettype wire

FILE: design/white_blob_steering_top.sv
// Top level of the white blob steering block.
//
// Pixels arrive in raster order on the pixel channel (red, green, blue and
// frame_end), one word per cycle while ready is high. Each pixel in the
// middle third of the frame that is pure white is counted and its column
// summed. The pixel marked frame_end closes the frame: a serial divider
// then forms the mean column, one quotient bit per cycle, and the steering
// word (steer, mean_column, white_count) is written to the output register.
// Ready stays low from the cycle after the frame_end pixel until that word
// is loaded, through the divider steps and the load step, which waits while
// an earlier word is still held. Otherwise one pixel is taken per cycle.
// A stalled receiver holds the result word in the output register while new
// pixels keep arriving; only the load of the next frame's word waits for it
// to be taken. The user must write frame_width and frame_height through
// cfg_we, cfg_index and cfg_data only while the block is idle, which the
// block does not enforce. Synchronous reset restores a 640 by 480 frame,
// clears the counters and empties the output register.
`default_nettype none
module white_blob_steering_top #(
  parameter int COORD_BITS = wbs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  wbs_pixel_if.sink                           pixel,
  wbs_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic [wbs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wbs_pkg::CFG_BITS-1:0]        cfg_data
);
  wbs_pkg::cmd_t cmd;
  logic          in_ready;
  logic          out_valid;

  assign pixel.ready  = in_ready;
  assign result.valid = out_valid;

  wbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pixel.valid),
    .in_frame_end (pixel.frame_end),
    .in_ready     (in_ready),
    .out_ready    (result.ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  wbs_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .red         (pixel.red),
    .green       (pixel.green),
    .blue        (pixel.blue),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .steer       (result.steer),
    .mean_column (result.mean_column),
    .white_count (result.white_count)
  );
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench of the white blob steering block: directed and random frames against a local tracker.
module testbench;
  localparam int COORD_BITS    = wbs_pkg::COORD_BITS_DEF;
  localparam int PIXEL_TARGET  = 500;
  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 33;

  typedef logic [wbs_pkg::CFG_BITS-1:0] cfg_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    wbs_pkg::steer_t                steer;
    logic [wbs_pkg::MEAN_BITS-1:0]  mean_column;
    logic [wbs_pkg::CNT_BITS-1:0]   white_count;
  } steer_word_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  wbs_pkg::reg_index_t          cfg_index;
  logic [wbs_pkg::CFG_BITS-1:0] cfg_data;

  wbs_pixel_if  pix ();
  wbs_result_if res ();

  white_blob_steering_top #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the geometry and of the per-frame counters.
  logic [wbs_pkg::CFG_BITS-1:0] track_width;
  logic [wbs_pkg::CFG_BITS-1:0] track_height;
  logic [COORD_BITS-1:0]        track_column;
  logic [wbs_pkg::IDX_BITS-1:0] track_index;
  logic [wbs_pkg::CNT_BITS-1:0] track_whites;
  logic [wbs_pkg::SUM_BITS-1:0] track_sum;

  steer_word_t steer_due[$];
  steer_word_t due_word;
  int          idle_pct = IDLE_PCT;
  int          pixels_sent = 0;
  int          words_checked = 0;
  int          failures = 0;
  int          quiet_cycles = 0;
  int          steer_hits [4] = '{0, 0, 0, 0};

  function automatic void clear_tracker();
    track_column = '0;
    track_index  = '0;
    track_whites = '0;
    track_sum    = '0;
  endfunction

  function automatic void track_pixel(input pixel_t px);
    logic [63:0] area;
    logic [63:0] pos;
    logic [63:0] sum_next;
    logic [63:0] mean;
    logic [63:0] third;
    logic [63:0] two_thirds;
    steer_word_t word;
    area = 64'(track_width) * 64'(track_height);
    pos  = 64'(track_index);
    if (3 * pos >= area && 3 * pos + 2 < 2 * area &&
        px.red == 8'hFF && px.green == 8'hFF && px.blue == 8'hFF) begin
      if (track_whites != '1) track_whites = track_whites + 1'b1;
      sum_next  = 64'(track_sum) + 64'(track_column);
      track_sum = (sum_next >> wbs_pkg::SUM_BITS) != 0 ? '1 :
                  sum_next[wbs_pkg::SUM_BITS-1:0];
    end
    if (32'(track_column) + 1 >= 32'(track_width)) track_column = '0;
    else track_column = track_column + 1'b1;
    if (track_index != '1) track_index = track_index + 1'b1;
    if (px.frame_end) begin
      mean = '0;
      word.white_count = track_whites;
      if (track_whites == 0) begin
        word.steer = wbs_pkg::STEER_SEARCH;
      end else begin
        third      = 64'(track_width) / 3;
        two_thirds = 64'(track_width) * 2 / 3;
        mean       = 64'(track_sum) / 64'(track_whites);
        if (mean < third) word.steer = wbs_pkg::STEER_LEFT;
        else if (mean > two_thirds) word.steer = wbs_pkg::STEER_RIGHT;
        else word.steer = wbs_pkg::STEER_STRAIGHT;
      end
      word.mean_column = mean[wbs_pkg::MEAN_BITS-1:0];
      steer_due.push_back(word);
      clear_tracker();
    end
  endfunction

  // A non-white pixel is often near white: two channels full, the third below full.
  function automatic pixel_t make_pixel(input bit white, input bit last);
    pixel_t px;
    px.frame_end = last;
    px.red   = 8'($urandom);
    px.green = 8'($urandom);
    px.blue  = 8'($urandom);
    if (white) begin
      px.red   = 8'hFF;
      px.green = 8'hFF;
      px.blue  = 8'hFF;
    end else if ($urandom_range(3) != 0) begin
      px.red   = 8'hFF;
      px.green = 8'hFF;
      px.blue  = 8'hFF;
      case ($urandom_range(2))
        0: px.red   = 8'($urandom_range(254));
        1: px.green = 8'($urandom_range(254));
        default: px.blue = 8'($urandom_range(254));
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid     <= 1'b1;
    pix.red       <= px.red;
    pix.green     <= px.green;
    pix.blue      <= px.blue;
    pix.frame_end <= px.frame_end;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    track_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_mapped_frame(input int len, input logic [4:0] white_map);
    for (int i = 0; i < len; i++) send_pixel(make_pixel(white_map[i], i == len - 1));
  endtask

  // Waits until every expected word has been taken and the divider has had time to finish.
  task automatic settle();
    pix.valid <= 1'b0;
    while (steer_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input cfg_word_t w, input cfg_word_t h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= wbs_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    track_width = w;
    cfg_index <= wbs_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    track_height = h;
    cfg_we <= 1'b0;
  endtask

  task automatic pick_geometry();
    if ($urandom_range(99) < 85)
      set_frame(cfg_word_t'($urandom_range(1, 10)), cfg_word_t'($urandom_range(1, 4)));
    else
      set_frame(cfg_word_t'($urandom_range(1, 4095)), cfg_word_t'($urandom_range(1, 4095)));
  endtask

  // A tidy frame of at most 64 pixels is exactly width times height pixels
  // long; other frames take 1 to 24 pixels, and an untidy one may close early.
  task automatic send_random_frame(input bit tidy);
    logic [63:0] area;
    int          len;
    int          blob;
    bit          in_blob;
    bit          white;
    bit          last;
    area = 64'(track_width) * 64'(track_height);
    blob = $urandom_range(3);
    if (tidy && area <= 64) len = int'(area);
    else len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      in_blob = (32'(track_column) * 3 / 32'(track_width)) == blob;
      if (blob == 3) white = $urandom_range(99) < 15;
      else white = $urandom_range(99) < (in_blob ? 80 : 8);
      last = (i == len - 1) || (!tidy && $urandom_range(99) < 5);
      send_pixel(make_pixel(white, last));
    end
  endtask

  task automatic test_reset_geometry();
    // With the 640 by 480 reset geometry the first pixels lie far before the scan window.
    send_mapped_frame(2, 5'b00011);
  endtask

  task automatic test_steering_codes();
    // A 4 by 2 frame scans only pixel 3 (column 3) and pixel 4 (column 0).
    set_frame(12'd4, 12'd2);
    send_mapped_frame(4, 5'b01000);
    send_mapped_frame(5, 5'b10000);
    send_mapped_frame(5, 5'b11000);
    send_mapped_frame(3, 5'b00111);
  endtask

  task automatic test_degenerate_frames();
    // One column of three rows: pixel 1 alone is scanned, and both thirds are zero.
    set_frame(12'd1, 12'd3);
    send_mapped_frame(2, 5'b00011);
    // Zero width gives an empty window, so white pixels are never counted.
    set_frame(12'd0, 12'd7);
    send_mapped_frame(2, 5'b00011);
    set_frame(12'd4095, 12'd4095);
    send_pixel(pixel_t'{8'h00, 8'h00, 8'h00, 1'b1});
    set_frame(12'd1, 12'd1);
    send_mapped_frame(1, 5'b00001);
  endtask

  task automatic test_back_to_back();
    set_frame(12'd7, 12'd3);
    idle_pct = 0;
    repeat (6) send_random_frame(1'b1);
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_frames();
    int start;
    start = pixels_sent;
    while (pixels_sent - start < PIXEL_TARGET) begin
      pick_geometry();
      repeat ($urandom_range(1, 4)) send_random_frame($urandom_range(99) < 80);
    end
  endtask

  always @(posedge clk) res.ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (steer_due.size() == 0) begin
        $error("unexpected steering word: steer %0d mean_column %0d white_count %0d",
               res.steer, res.mean_column, res.white_count);
        failures++;
      end else begin
        due_word = steer_due.pop_front();
        if (res.steer !== due_word.steer) begin
          $error("steer: expected %0d, got %0d", due_word.steer, res.steer);
          failures++;
        end
        if (res.mean_column !== due_word.mean_column) begin
          $error("mean_column: expected %0d, got %0d", due_word.mean_column, res.mean_column);
          failures++;
        end
        if (res.white_count !== due_word.white_count) begin
          $error("white_count: expected %0d, got %0d", due_word.white_count, res.white_count);
          failures++;
        end
        steer_hits[due_word.steer]++;
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no word moved on either channel for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = wbs_pkg::REG_FRAME_WIDTH;
    cfg_data      = '0;
    pix.valid     = 1'b0;
    pix.red       = '0;
    pix.green     = '0;
    pix.blue      = '0;
    pix.frame_end = 1'b0;
    res.ready     = 1'b0;
    track_width   = wbs_pkg::WIDTH_RESET;
    track_height  = wbs_pkg::HEIGHT_RESET;
    clear_tracker();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_steering_codes();
    test_degenerate_frames();
    test_back_to_back();
    test_random_frames();
    settle();
    $display("summary: %0d pixels sent, %0d steering words checked",
             pixels_sent, words_checked);
    $display("summary: search %0d, left %0d, straight %0d, right %0d",
             steer_hits[wbs_pkg::STEER_SEARCH], steer_hits[wbs_pkg::STEER_LEFT],
             steer_hits[wbs_pkg::STEER_STRAIGHT], steer_hits[wbs_pkg::STEER_RIGHT]);
    if (failures == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
